// ===== hw/rtl/moving_median_filter_core_defines.svh =====
// Assertion macros for the running median filter port checker.
`ifndef MOVING_MEDIAN_FILTER_CORE_DEFINES_SVH
`define MOVING_MEDIAN_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("moving median filter: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("moving median filter: next-cycle check failed");

`endif

// ===== hw/rtl/mmf_pkg.sv =====
// Shared types and constants of the running median filter.
package mmf_pkg;

  // Width of the window size write data.
  localparam int unsigned CFG_BITS = 5;

  // Window size after reset, before clamping to the cell count.
  localparam int unsigned RESET_WINDOW = 9;

  // Flags a cell hands right; gt also goes to the left neighbor.
  typedef struct packed {
    logic gt;    // stored value is greater than the incoming sample
    logic gone;  // the slot being replaced sits at or left of this cell
  } cell_flags_t;

endpackage

// ===== hw/rtl/moving_median_filter_core.sv =====
// Top level of the running median filter: sorted cell row plus median output stage.
//
// Running median over the last window_size samples (1 to MAX_WINDOW). The window
// lives in a row of MAX_WINDOW cells kept in ascending order; each accepted sample
// replaces the oldest entry and is sorted into place at the accepting edge, so the
// filter sustains one sample per clock while the output is not stalled. The result,
// twice the median, is registered after the cell row: the accepting edge writes the
// cell row, and a later edge, once the output register is free or being drained,
// loads the middle-value select and add into it. A window_size write clamps the
// value to 1..MAX_WINDOW and clears the window to zeros in the same cycle; write it
// only while no sample is in flight. The configuration port is always ready.
module moving_median_filter_core #(
  parameter int unsigned MAX_WINDOW  = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [mmf_pkg::CFG_BITS-1:0]  window_size_i,
  input  logic                                 sample_valid_i,
  output logic                                 sample_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic                                 median_valid_o,
  input  logic                                 median_ready_i,
  output logic signed [SAMPLE_BITS:0]          median_twice_o
);

  localparam int unsigned SizeBits = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TagBits  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CmpBits  = (SizeBits > mmf_pkg::CFG_BITS) ?
                                     SizeBits : mmf_pkg::CFG_BITS;
  localparam int unsigned ResetSize = (mmf_pkg::RESET_WINDOW > MAX_WINDOW) ?
                                      MAX_WINDOW : mmf_pkg::RESET_WINDOW;

  logic                          cfg_fire;
  logic                          in_fire;
  logic                          out_adv;
  logic [SizeBits-1:0]           size_q, size_d;
  logic [CmpBits-1:0]            cfg_ext;
  logic [TagBits-1:0]            wp_q, wp_d;
  logic                          pend_q, pend_d;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS:0]   out_q;
  logic [SizeBits-1:0]           half;
  logic signed [SAMPLE_BITS-1:0] hi_val, lo_val;
  logic signed [SAMPLE_BITS:0]   twice;

  logic signed [SAMPLE_BITS-1:0] cell_val   [MAX_WINDOW];
  logic        [TagBits-1:0]     cell_tag   [MAX_WINDOW];
  mmf_pkg::cell_flags_t          cell_flags [MAX_WINDOW];

  // Handshakes: a stage advances when the output register is free or being drained.
  assign cfg_ready_o    = 1'b1;
  assign cfg_fire       = cfg_valid_i;
  assign out_adv        = !out_valid_q || median_ready_i;
  assign sample_ready_o = !pend_q || out_adv;
  assign in_fire        = sample_valid_i && sample_ready_o;

  // Clamp the written window size to 1..MAX_WINDOW.
  assign cfg_ext = CmpBits'(window_size_i);
  always_comb begin
    priority if (cfg_ext == '0) begin
      size_d = SizeBits'(1);
    end else if (cfg_ext > CmpBits'(MAX_WINDOW)) begin
      size_d = SizeBits'(MAX_WINDOW);
    end else begin
      size_d = SizeBits'(cfg_ext);
    end
  end

  // Advance the write slot, wrapping at the window size.
  assign wp_d = (SizeBits'(wp_q) + SizeBits'(1) == size_q) ? '0 : wp_q + TagBits'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeBits'(ResetSize);
      wp_q   <= '0;
    end else if (cfg_fire) begin
      size_q <= size_d;
      wp_q   <= '0;
    end else if (in_fire) begin
      wp_q   <= wp_d;
    end
  end

  // Row of sorting cells.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] l_val, r_val;
    logic        [TagBits-1:0]     l_tag, r_tag;
    mmf_pkg::cell_flags_t          l_flags;
    logic                          r_gt;
    logic                          active;
    logic                          last;

    assign active = SizeBits'(i) < size_q;
    assign last   = SizeBits'(i + 1) == size_q;

    if (i == 0) begin : g_first
      assign l_val   = '0;
      assign l_tag   = '0;
      assign l_flags = '0;
    end else begin : g_inner_l
      assign l_val   = cell_val[i-1];
      assign l_tag   = cell_tag[i-1];
      assign l_flags = cell_flags[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign r_val = '0;
      assign r_tag = '0;
      assign r_gt  = 1'b1;
    end else begin : g_inner_r
      assign r_val = cell_val[i+1];
      assign r_tag = cell_tag[i+1];
      assign r_gt  = last || cell_flags[i+1].gt;
    end

    mmf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TAG_BITS    (TagBits),
      .TAG_INIT    (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .clear_i      (cfg_fire),
      .load_i       (in_fire),
      .active_i     (active),
      .sample_i     (sample_i),
      .slot_i       (wp_q),
      .left_val_i   (l_val),
      .left_tag_i   (l_tag),
      .left_flags_i (l_flags),
      .right_val_i  (r_val),
      .right_tag_i  (r_tag),
      .right_gt_i   (r_gt),
      .val_o        (cell_val[i]),
      .tag_o        (cell_tag[i]),
      .flags_o      (cell_flags[i])
    );
  end

  // Pick the middle value(s) from the row.
  assign half = size_q >> 1;
  always_comb begin
    hi_val = '0;
    lo_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      hi_val = hi_val | (cell_val[i] & {SAMPLE_BITS{SizeBits'(i) == half}});
      lo_val = lo_val | (cell_val[i] & {SAMPLE_BITS{SizeBits'(i + 1) == half}});
    end
  end

  // Odd size doubles the middle value, even size adds the two middle values.
  assign twice = size_q[0] ? {hi_val, 1'b0} :
                 ({hi_val[SAMPLE_BITS-1], hi_val} + {lo_val[SAMPLE_BITS-1], lo_val});

  // Track a sorted row whose median is still owed, then hold the result beat.
  assign pend_d = in_fire || (pend_q && !out_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_adv) begin
        out_valid_q <= pend_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && pend_q) begin
      out_q <= twice;
    end
  end

  assign median_valid_o = out_valid_q;
  assign median_twice_o = out_q;

endmodule

// ===== hw/rtl/mmf_cell.sv =====
// One cell of the sorted row: holds one window value and the slot it came from.
module mmf_cell #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned TAG_BITS    = 4,
  parameter int unsigned TAG_INIT    = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          load_i,
  input  logic                          active_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic        [TAG_BITS-1:0]    slot_i,
  input  logic signed [SAMPLE_BITS-1:0] left_val_i,
  input  logic        [TAG_BITS-1:0]    left_tag_i,
  input  mmf_pkg::cell_flags_t          left_flags_i,
  input  logic signed [SAMPLE_BITS-1:0] right_val_i,
  input  logic        [TAG_BITS-1:0]    right_tag_i,
  input  logic                          right_gt_i,
  output logic signed [SAMPLE_BITS-1:0] val_o,
  output logic        [TAG_BITS-1:0]    tag_o,
  output mmf_pkg::cell_flags_t          flags_o
);

  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  logic        [TAG_BITS-1:0]    tag_q, tag_d;
  logic                          own_gt;
  logic                          own_hit;
  logic                          shifted;
  logic                          self_gt;
  logic signed [SAMPLE_BITS-1:0] self_val;
  logic        [TAG_BITS-1:0]    self_tag;
  logic                          side_gt;
  logic signed [SAMPLE_BITS-1:0] side_val;
  logic        [TAG_BITS-1:0]    side_tag;

  // Compare against the new sample and spot the slot being replaced.
  assign own_gt  = val_q > sample_i;
  assign own_hit = active_i && (tag_q == slot_i);
  assign shifted = left_flags_i.gone || own_hit;

  // Close the gap: once the dropped entry lies at or left of here, pull from the right.
  assign self_gt  = shifted ? right_gt_i  : own_gt;
  assign self_val = shifted ? right_val_i : val_q;
  assign self_tag = shifted ? right_tag_i : tag_q;

  // The element that ends up just left of this place after the drop.
  assign side_gt  = left_flags_i.gone ? own_gt : left_flags_i.gt;
  assign side_val = left_flags_i.gone ? val_q  : left_val_i;
  assign side_tag = left_flags_i.gone ? tag_q  : left_tag_i;

  // Insert the new sample where the order breaks, shift larger values right.
  always_comb begin
    val_d = val_q;
    tag_d = tag_q;
    if (load_i && active_i) begin
      if (!self_gt) begin
        val_d = self_val;
        tag_d = self_tag;
      end else if (!side_gt) begin
        val_d = sample_i;
        tag_d = slot_i;
      end else begin
        val_d = side_val;
        tag_d = side_tag;
      end
    end
  end

  // Hold the entry; clear it to zero in its home slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      tag_q <= TAG_BITS'(TAG_INIT);
    end else if (clear_i) begin
      val_q <= '0;
      tag_q <= TAG_BITS'(TAG_INIT);
    end else begin
      val_q <= val_d;
      tag_q <= tag_d;
    end
  end

  assign val_o        = val_q;
  assign tag_o        = tag_q;
  assign flags_o.gt   = own_gt;
  assign flags_o.gone = shifted;

endmodule

// ===== hw/rtl/mmf_checker.sv =====
// Port-level checks for the running median filter, bound to the top level.
`include "moving_median_filter_core_defines.svh"

module mmf_checker #(
  parameter int unsigned MAX_WINDOW  = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic        [mmf_pkg::CFG_BITS-1:0] window_size_i,
  input logic                               sample_ready_o,
  input logic                               median_valid_o,
  input logic                               median_ready_i,
  input logic signed [SAMPLE_BITS:0]        median_twice_o
);

  localparam int unsigned ResetSize = (mmf_pkg::RESET_WINDOW > MAX_WINDOW) ?
                                      MAX_WINDOW : mmf_pkg::RESET_WINDOW;

  logic odd_q;
  logic odd_d;
  logic stall;

  // Parity of the clamped window size being written.
  always_comb begin
    priority if (window_size_i == '0) begin
      odd_d = 1'b1;
    end else if (32'(window_size_i) > MAX_WINDOW) begin
      odd_d = (MAX_WINDOW % 2) == 1;
    end else begin
      odd_d = window_size_i[0];
    end
  end

  // Track whether the active window size is odd.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_q <= (ResetSize % 2) == 1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      odd_q <= odd_d;
    end
  end

  assign stall = median_valid_o && !median_ready_i;

  `MMF_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, stall, median_valid_o)
  `MMF_ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, stall, $stable(median_twice_o))
  `MMF_ASSERT_NOW(a_ready_when_drained, clk_i, rst_ni, !median_valid_o, sample_ready_o)
  `MMF_ASSERT_NOW(a_odd_size_even_result, clk_i, rst_ni, median_valid_o && odd_q,
                  !median_twice_o[0])

endmodule

bind moving_median_filter_core mmf_checker #(
  .MAX_WINDOW  (MAX_WINDOW),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mmf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o),
  .window_size_i  (window_size_i),
  .sample_ready_o (sample_ready_o),
  .median_valid_o (median_valid_o),
  .median_ready_i (median_ready_i),
  .median_twice_o (median_twice_o)
);

// ===== tb/sv/moving_median_filter_check.sv =====
// Checker for the running median filter: window predictor and median scoreboard.
module moving_median_filter_check #(
  parameter int unsigned MAX_WIN  = 16,
  parameter int unsigned SAMPLE_W = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic        [mmf_pkg::CFG_BITS-1:0] window_size_i,
  input  logic                               sample_valid_i,
  input  logic                               sample_ready_i,
  input  logic signed [SAMPLE_W-1:0]         sample_i,
  input  logic                               median_valid_i,
  input  logic                               median_ready_i,
  input  logic signed [SAMPLE_W:0]           median_twice_i,
  output int                                 pending_o,
  output int                                 mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted window contents, in arrival slots, and where the next sample lands
  logic signed [SAMPLE_W-1:0] recent [MAX_WIN];
  int unsigned                span;
  int unsigned                oldest_slot;
  int                         fails;

  // Medians predicted for accepted samples, oldest first
  logic signed [SAMPLE_W:0]   median_q [$];

  task automatic clear_window();
    for (int i = 0; i < MAX_WIN; i++) recent[i] = '0;
    oldest_slot = 0;
  endtask

  // Sort the live part of the window and return twice its median
  function automatic logic signed [SAMPLE_W:0] window_median();
    logic signed [SAMPLE_W-1:0] ord [MAX_WIN];
    logic signed [SAMPLE_W-1:0] key;
    logic signed [SAMPLE_W:0]   lo;
    logic signed [SAMPLE_W:0]   hi;
    int                         j;
    int unsigned                half;
    for (int i = 0; i < MAX_WIN; i++) ord[i] = recent[i];
    for (int i = 1; i < span; i++) begin
      key = ord[i];
      j   = i;
      while (j > 0 && ord[j-1] > key) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = key;
    end
    half = span / 2;
    hi   = ord[half];
    if (span % 2) return hi + hi;
    lo = ord[half-1];
    return lo + hi;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [SAMPLE_W:0] want;
    int unsigned              v;
    if (!rst_ni) begin
      span  = (mmf_pkg::RESET_WINDOW > MAX_WIN) ? MAX_WIN : mmf_pkg::RESET_WINDOW;
      fails = 0;
      clear_window();
      median_q.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      // Compare the departing median beat with the oldest prediction
      if (median_valid_i && median_ready_i) begin
        if (median_q.size() == 0) begin
          $display("%0t: median beat with none expected: expected none, actual %0d",
                   $time, median_twice_i);
          fails++;
        end else begin
          want = median_q.pop_front();
          if (median_twice_i !== want) begin
            $display("%0t: median_twice mismatch: expected %0d, actual %0d",
                     $time, want, median_twice_i);
            fails++;
          end
        end
      end

      // Take a new window size: clamp to 1..MAX_WIN and drop the old window
      if (cfg_valid_i && cfg_ready_i) begin
        v = window_size_i;
        if (v < 1) v = 1;
        if (v > MAX_WIN) v = MAX_WIN;
        span = v;
        clear_window();
      end

      // Overwrite the oldest sample and predict the new median
      if (sample_valid_i && sample_ready_i) begin
        if (oldest_slot >= span) oldest_slot = 0;
        recent[oldest_slot] = sample_i;
        oldest_slot++;
        if (oldest_slot >= span) oldest_slot = 0;
        median_q.push_back(window_median());
      end

      pending_o    <= median_q.size();
      mismatches_o <= fails;
    end
  end

endmodule

// ===== tb/sv/tb_moving_median_filter_core.sv =====
// Testbench top of the running median filter: clock, reset, stimulus and verdict.
module tb_moving_median_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_WIN  = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PHASES   = 12;
  localparam int unsigned PER_PHASE = 155;

  // Window sizes of the first random phases: extremes, clamped codes, odd and even
  localparam logic [mmf_pkg::CFG_BITS-1:0] SIZE_PLAN [9] =
    '{5'd1, 5'd16, 5'd2, 5'd15, 5'd0, 5'd31, 5'd17, 5'd3, 5'd8};

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic        [mmf_pkg::CFG_BITS-1:0] window_size_i;
  logic                               sample_valid_i;
  logic                               sample_ready_o;
  logic signed [SAMPLE_W-1:0]         sample_i;
  logic                               median_valid_o;
  logic                               median_ready_i;
  logic signed [SAMPLE_W:0]           median_twice_o;

  int pending;
  int mismatches;
  int phase_no = -1;
  bit calm     = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  moving_median_filter_core #(
    .MAX_WINDOW  (MAX_WIN),
    .SAMPLE_BITS (SAMPLE_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .window_size_i  (window_size_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .median_valid_o (median_valid_o),
    .median_ready_i (median_ready_i),
    .median_twice_o (median_twice_o)
  );

  moving_median_filter_check #(
    .MAX_WIN  (MAX_WIN),
    .SAMPLE_W (SAMPLE_W)
  ) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .window_size_i  (window_size_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_i (sample_ready_o),
    .sample_i       (sample_i),
    .median_valid_i (median_valid_o),
    .median_ready_i (median_ready_i),
    .median_twice_i (median_twice_o),
    .pending_o      (pending),
    .mismatches_o   (mismatches)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2_400_000;
    $display("tb_moving_median_filter_core failed");
    $finish;
  end

  // Offer one sample beat, with random gaps, and hold it until accepted
  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 14) begin
      sample_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    do @(posedge clk_i); while (!sample_ready_o);
  endtask

  // Drain the filter, then write a new window size
  task automatic write_window(input logic [mmf_pkg::CFG_BITS-1:0] v);
    @(negedge clk_i);
    sample_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (3) @(negedge clk_i);
    cfg_valid_i   <= 1'b1;
    window_size_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mix of full-range noise, clustered small values with ties, and corners
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    int          near;
    r    = $urandom();
    near = int'($urandom_range(8)) - 4;
    case ($urandom_range(9))
      0, 1: begin
        case (r[1:0])
          2'd0:    return 16'sh7fff;
          2'd1:    return 16'sh8000;
          2'd2:    return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      2, 3, 4: return near[SAMPLE_W-1:0];
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off, and a calm stretch
  initial begin
    median_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        median_ready_i <= 1'b0;
      end else if (!hold_done && phase_no == 3) begin
        hold_done = 1'b1;
        hold_left = 300;
        median_ready_i <= 1'b0;
      end else begin
        median_ready_i <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    cfg_valid_i    = 1'b0;
    window_size_i  = '0;
    sample_valid_i = 1'b0;
    sample_i       = '0;
    rst_ni         = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset window of nine, still partly filled with cleared zeros
    offer_sample(16'sh7fff);
    offer_sample(16'sh8000);
    offer_sample(16'shffff);
    offer_sample(16'sh0001);
    offer_sample(16'sh5555);
    offer_sample(16'shaaaa);

    // Size zero clamps to one: output reaches both extremes
    write_window(5'd0);
    offer_sample(16'sh8000);
    offer_sample(16'sh7fff);

    // Oversized write clamps to the full window; even size over zeros
    write_window(5'd31);
    offer_sample(16'sh7fff);
    offer_sample(16'sh7fff);
    offer_sample(16'sh7fff);

    // Window of two: sum of the middle pair at both extremes
    write_window(5'd2);
    offer_sample(16'sh7fff);
    offer_sample(16'sh7fff);
    offer_sample(16'sh8000);
    offer_sample(16'sh8000);
    offer_sample(16'sh8000);

    // Random phases, each under its own window size
    for (int p = 0; p < PHASES; p++) begin
      write_window((p < 9) ? SIZE_PLAN[p] : mmf_pkg::CFG_BITS'($urandom_range(31)));
      phase_no = p;
      calm     = (p == 5);
      for (int k = 0; k < PER_PHASE; k++) offer_sample(pick_sample());
    end
    calm = 1'b0;

    // Drain and give the verdict
    @(negedge clk_i);
    sample_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_moving_median_filter_core passed");
    end else begin
      $display("tb_moving_median_filter_core failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mmf_pkg.sv
hw/rtl/mmf_cell.sv
hw/rtl/moving_median_filter_core.sv
hw/rtl/mmf_checker.sv
tb/sv/moving_median_filter_check.sv
tb/sv/tb_moving_median_filter_core.sv
